@@ sv/assert_macros.svh @@
// Assertion helpers shared by the translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ sv/tlbpt_pkg.sv @@
package tlbpt_pkg;

    localparam int OFFSET_BITS = 8;
    localparam int PAGE_COUNT  = 256;
    localparam int TLB_ENTRIES = 16;
    localparam int FRAME_COUNT = 256;

    localparam int VA_W    = 32;
    localparam int PA_W    = 16;
    localparam int FU_W    = 8;
    localparam int CNT_W   = 32;
    localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int TLB_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    localparam logic [1:0] ST_TLB_HIT = 2'd0;
    localparam logic [1:0] ST_PT_HIT  = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic               fill;
        logic [PAGE_W-1:0]  fill_page;
        logic [FRAME_W-1:0] fill_frame;
        logic               drop;
        logic [PAGE_W-1:0]  drop_page;
    } tlb_upd_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } tlb_look_t;

endpackage

@@ sv/tlbpt_ram.sv @@
module tlbpt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/tlbpt_tlb.sv @@
`include "assert_macros.svh"

module tlbpt_tlb (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tlbpt_pkg::PAGE_W-1:0]  look_page,
    output tlbpt_pkg::tlb_look_t          look,
    input  tlbpt_pkg::tlb_upd_t           upd
);
    import tlbpt_pkg::*;

    logic               valid_reg [TLB_ENTRIES];
    logic [PAGE_W-1:0]  page_reg  [TLB_ENTRIES];
    logic [FRAME_W-1:0] frame_reg [TLB_ENTRIES];
    logic [TLB_W-1:0]   fill_ptr_reg;
    logic [TLB_W-1:0]   fill_ptr_next;
    logic [TLB_ENTRIES-1:0] match;

    always_comb
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (page_reg[i] == look_page);
        end
    end

    // Lowest matching slot wins, so scan from the top down.
    always_comb
    begin
        look.hit   = |match;
        look.frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                look.frame = frame_reg[i];
            end
        end
    end

    always_comb
    begin
        if ((32'(fill_ptr_reg) + 32'd1) >= 32'(TLB_ENTRIES))
        begin
            fill_ptr_next = '0;
        end
        else
        begin
            fill_ptr_next = fill_ptr_reg + TLB_W'(1);
        end
    end

    // The drop of the evicted page comes first; the fill of the new page overrides it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            fill_ptr_reg <= '0;
        end
        else
        begin
            if (upd.drop)
            begin
                for (int i = 0; i < TLB_ENTRIES; i++)
                begin
                    if (valid_reg[i] && (page_reg[i] == upd.drop_page))
                    begin
                        valid_reg[i] <= 1'b0;
                    end
                end
            end
            if (upd.fill)
            begin
                valid_reg[fill_ptr_reg] <= 1'b1;
                fill_ptr_reg <= fill_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.fill)
        begin
            page_reg[fill_ptr_reg]  <= upd.fill_page;
            frame_reg[fill_ptr_reg] <= upd.fill_frame;
        end
    end

    `ASSERT_PROP(a_fill_sets_valid, clk, rst_n, upd.fill |=> valid_reg[$past(fill_ptr_reg)])
    `ASSERT_PROP(a_ptr_holds, clk, rst_n, !upd.fill |=> $stable(fill_ptr_reg))
    `ASSERT_PROP(a_single_match, clk, rst_n, $onehot0(match))

endmodule

@@ sv/tlb_page_table_translator_top.sv @@
// Channel   Direction  Handshake          Payload
// request   in         start, busy        vaddr
// result    out        done (one cycle)   paddr, status, frame_used,
//                                         tlb_hit_count, fault_count
//
// A request is accepted in idle and resolved in lookup: the accept edge reads the
// page table and frame owner memories, and the lookup edge resolves TLB, page table
// or fault and writes the memories back. done and the result are registered at that
// edge, as busy goes low; a new request can be accepted while done shows the last one.
// Reset clears the page valid bits, the TLB, the frame pointer, its wrap flag
// and the counters at once. The receiver cannot stall; results are never held.

`include "assert_macros.svh"

module tlb_page_table_translator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tlbpt_pkg::VA_W-1:0]     vaddr,
    output logic                           done,
    output logic [tlbpt_pkg::PA_W-1:0]     paddr,
    output logic [1:0]                     status,
    output logic [tlbpt_pkg::FU_W-1:0]     frame_used,
    output logic [tlbpt_pkg::CNT_W-1:0]    tlb_hit_count,
    output logic [tlbpt_pkg::CNT_W-1:0]    fault_count
);
    import tlbpt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_LOOKUP
    } state_t;

    state_t                 state_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   invalid_reg;
    logic [FRAME_W-1:0]     next_frame_reg;
    logic [FRAME_W-1:0]     next_frame_next;
    logic                   page_valid_reg  [PAGE_COUNT];
    logic                   frames_wrapped_reg;
    logic                   done_reg;
    logic [PA_W-1:0]        phys_reg;
    logic [1:0]             status_reg;
    logic [FU_W-1:0]        frame_used_reg;
    logic [CNT_W-1:0]       hit_cnt_reg;
    logic [CNT_W-1:0]       fault_cnt_reg;

    logic                   accept;
    logic                   in_invalid;
    logic [PAGE_W-1:0]      in_page;
    logic [FRAME_W-1:0]     pt_frame;
    logic [PAGE_W-1:0]      old_owner;
    logic                   is_fault;
    logic                   old_owned;
    logic [1:0]             status_next;
    logic [FRAME_W-1:0]     frame_sel;
    logic [VA_W-1:0]        phys_wide;
    tlb_look_t              look;
    tlb_upd_t               upd;

    assign accept     = start && (state_reg == S_IDLE);
    assign in_invalid = (vaddr >> OFFSET_BITS) >= VA_W'(PAGE_COUNT);
    assign in_page    = vaddr[OFFSET_BITS +: PAGE_W];

    tlbpt_ram #(
        .DEPTH (PAGE_COUNT),
        .WIDTH (FRAME_W)
    ) u_page_frame (
        .clk   (clk),
        .we    (is_fault),
        .waddr (page_reg),
        .wdata (next_frame_reg),
        .re    (accept),
        .raddr (in_page),
        .rdata (pt_frame)
    );

    tlbpt_ram #(
        .DEPTH (FRAME_COUNT),
        .WIDTH (PAGE_W)
    ) u_frame_owner (
        .clk   (clk),
        .we    (is_fault),
        .waddr (next_frame_reg),
        .wdata (page_reg),
        .re    (accept),
        .raddr (next_frame_reg),
        .rdata (old_owner)
    );

    tlbpt_tlb u_tlb (
        .clk       (clk),
        .rst_n     (rst_n),
        .look_page (page_reg),
        .look      (look),
        .upd       (upd)
    );

    always_comb
    begin
        if ((32'(next_frame_reg) + 32'd1) >= 32'(FRAME_COUNT))
        begin
            next_frame_next = '0;
        end
        else
        begin
            next_frame_next = next_frame_reg + FRAME_W'(1);
        end
    end

    // Frames are handed out in order, so the next frame already has an owner
    // exactly when the frame pointer has wrapped at least once.
    always_comb
    begin
        is_fault  = 1'b0;
        old_owned = frames_wrapped_reg;
        frame_sel = '0;
        if (invalid_reg)
        begin
            status_next = ST_INVALID;
        end
        else if (look.hit)
        begin
            status_next = ST_TLB_HIT;
            frame_sel   = look.frame;
        end
        else if (page_valid_reg[page_reg])
        begin
            status_next = ST_PT_HIT;
            frame_sel   = pt_frame;
        end
        else
        begin
            status_next = ST_FAULT;
            frame_sel   = next_frame_reg;
            is_fault    = (state_reg == S_LOOKUP);
        end
        if (state_reg != S_LOOKUP)
        begin
            is_fault = 1'b0;
        end
        phys_wide = (VA_W'(frame_sel) << OFFSET_BITS) | VA_W'(offset_reg);

        upd.fill       = is_fault;
        upd.fill_page  = page_reg;
        upd.fill_frame = next_frame_reg;
        upd.drop       = is_fault && old_owned;
        upd.drop_page  = old_owner;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            page_reg           <= '0;
            offset_reg         <= '0;
            invalid_reg        <= 1'b0;
            next_frame_reg     <= '0;
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                page_valid_reg[i] <= 1'b0;
            end
            frames_wrapped_reg <= 1'b0;
            done_reg           <= 1'b0;
            phys_reg           <= '0;
            status_reg         <= ST_TLB_HIT;
            frame_used_reg     <= '0;
            hit_cnt_reg        <= '0;
            fault_cnt_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        page_reg    <= in_page;
                        offset_reg  <= vaddr[OFFSET_BITS-1:0];
                        invalid_reg <= in_invalid;
                        state_reg   <= S_LOOKUP;
                    end
                end
                S_LOOKUP:
                begin
                    state_reg      <= S_IDLE;
                    done_reg       <= 1'b1;
                    status_reg     <= status_next;
                    phys_reg       <= invalid_reg ? '0 : phys_wide[PA_W-1:0];
                    frame_used_reg <= FU_W'(frame_sel);
                    if (status_next == ST_TLB_HIT)
                    begin
                        hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
                    end
                    if (is_fault)
                    begin
                        fault_cnt_reg  <= fault_cnt_reg + CNT_W'(1);
                        next_frame_reg <= next_frame_next;
                        if (next_frame_next == '0)
                        begin
                            frames_wrapped_reg <= 1'b1;
                        end
                        // The frame's previous page loses its mapping before the new one lands.
                        if (old_owned)
                        begin
                            page_valid_reg[old_owner] <= 1'b0;
                        end
                        page_valid_reg[page_reg] <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg == S_LOOKUP);
    assign done          = done_reg;
    assign paddr         = phys_reg;
    assign status        = status_reg;
    assign frame_used    = frame_used_reg;
    assign tlb_hit_count = hit_cnt_reg;
    assign fault_count   = fault_cnt_reg;

    `ASSERT_PROP(a_done_after_lookup, clk, rst_n, done_reg |-> $past(state_reg == S_LOOKUP))
    `ASSERT_PROP(a_fault_counts, clk, rst_n, (done_reg && status_reg == ST_FAULT) |-> (fault_cnt_reg == $past(fault_cnt_reg) + CNT_W'(1)))
    `ASSERT_NEVER(a_invalid_no_fault, clk, rst_n, is_fault && invalid_reg)

endmodule

@@ verif/tlb_page_table_translator_top_test.sv @@
`timescale 1ns / 1ps

module tlb_page_table_translator_top_test;
    import tlbpt_pkg::*;

    typedef struct {
        logic [PA_W-1:0]  phys;
        logic [1:0]       stat;
        logic [FU_W-1:0]  frame;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] faults;
    } translation_t;

    class translation_scoreboard;
        bit                 page_valid [PAGE_COUNT];
        logic [FRAME_W-1:0] page_frame [PAGE_COUNT];
        bit                 tlb_valid [TLB_ENTRIES];
        logic [PAGE_W-1:0]  tlb_page [TLB_ENTRIES];
        logic [FRAME_W-1:0] tlb_frame [TLB_ENTRIES];
        bit                 frame_owned [FRAME_COUNT];
        logic [PAGE_W-1:0]  frame_owner [FRAME_COUNT];
        logic [TLB_W-1:0]   fill_slot = '0;
        logic [FRAME_W-1:0] next_frame = '0;
        logic [CNT_W-1:0]   hit_total = '0;
        logic [CNT_W-1:0]   fault_total = '0;
        translation_t       pending_results [$];
        int unsigned        mismatches = 0;

        function void fail(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s", $realtime, msg);
        endfunction

        // Works out the translation of one accepted request and updates the
        // TLB, page table and frame ownership the same way the block does.
        function void note_request(logic [VA_W-1:0] va);
            logic [VA_W-1:0]        page_num;
            logic [OFFSET_BITS-1:0] offset;
            logic [PAGE_W-1:0]      page;
            logic [PAGE_W-1:0]      old_page;
            logic [FRAME_W-1:0]     frame;
            bit                     found;
            translation_t           t;
            int                     i;

            page_num = va >> OFFSET_BITS;
            offset   = va[OFFSET_BITS-1:0];
            found    = 1'b0;
            frame    = '0;
            t.phys   = '0;
            t.frame  = '0;
            if (page_num >= PAGE_COUNT)
            begin
                t.stat = ST_INVALID;
            end
            else
            begin
                page = page_num[PAGE_W-1:0];
                for (i = 0; i < TLB_ENTRIES; i++)
                begin
                    if (!found && tlb_valid[i] && tlb_page[i] == page)
                    begin
                        frame = tlb_frame[i];
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    t.stat = ST_TLB_HIT;
                    hit_total++;
                end
                else if (page_valid[page])
                begin
                    t.stat = ST_PT_HIT;
                    frame  = page_frame[page];
                end
                else
                begin
                    t.stat     = ST_FAULT;
                    frame      = next_frame;
                    next_frame = (next_frame == FRAME_COUNT - 1) ? '0 : next_frame + 1'b1;
                    // A reused frame takes its mapping away from the page that held it.
                    if (frame_owned[frame])
                    begin
                        old_page = frame_owner[frame];
                        page_valid[old_page] = 1'b0;
                        for (i = 0; i < TLB_ENTRIES; i++)
                        begin
                            if (tlb_valid[i] && tlb_page[i] == old_page)
                                tlb_valid[i] = 1'b0;
                        end
                    end
                    frame_owned[frame]    = 1'b1;
                    frame_owner[frame]    = page;
                    page_valid[page]      = 1'b1;
                    page_frame[page]      = frame;
                    tlb_valid[fill_slot]  = 1'b1;
                    tlb_page[fill_slot]   = page;
                    tlb_frame[fill_slot]  = frame;
                    fill_slot = (fill_slot == TLB_ENTRIES - 1) ? '0 : fill_slot + 1'b1;
                    fault_total++;
                end
                t.phys  = PA_W'((32'(frame) << OFFSET_BITS) | 32'(offset));
                t.frame = FU_W'(frame);
            end
            t.hits   = hit_total;
            t.faults = fault_total;
            pending_results.push_back(t);
        endfunction

        function void check_result(logic [PA_W-1:0] phys, logic [1:0] stat,
                                   logic [FU_W-1:0] frame, logic [CNT_W-1:0] hits,
                                   logic [CNT_W-1:0] faults);
            translation_t w;

            if (pending_results.size() == 0)
            begin
                fail($sformatf("unexpected result: pa=%h st=%0d fr=%0d hits=%0d faults=%0d",
                               phys, stat, frame, hits, faults));
                return;
            end
            w = pending_results.pop_front();
            if (phys !== w.phys || stat !== w.stat || frame !== w.frame
                || hits !== w.hits || faults !== w.faults)
                fail($sformatf({"mismatch: want pa=%h st=%0d fr=%0d hits=%0d faults=%0d,",
                                " got pa=%h st=%0d fr=%0d hits=%0d faults=%0d"},
                               w.phys, w.stat, w.frame, w.hits, w.faults,
                               phys, stat, frame, hits, faults));
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [VA_W-1:0]  vaddr;
    logic             done;
    logic [PA_W-1:0]  paddr;
    logic [1:0]       status;
    logic [FU_W-1:0]  frame_used;
    logic [CNT_W-1:0] tlb_hit_count;
    logic [CNT_W-1:0] fault_count;

    translation_scoreboard sb = new;

    tlb_page_table_translator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .vaddr         (vaddr),
        .done          (done),
        .paddr         (paddr),
        .status        (status),
        .frame_used    (frame_used),
        .tlb_hit_count (tlb_hit_count),
        .fault_count   (fault_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Results are sampled with their pre-edge values at the edge that ends the strobe.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(paddr, status, frame_used, tlb_hit_count, fault_count);
    end

    // Holds start high until the block takes the request, then records it.
    task automatic send_request(input logic [VA_W-1:0] va);
        start <= 1'b1;
        vaddr <= va;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(va);
    endtask

    initial
    begin
        logic [VA_W-1:0]   directed_addrs [$];
        logic [PAGE_W-1:0] recent_pages [$];
        logic [VA_W-1:0]   va;
        logic [15:0]       upper;
        logic [PAGE_W-1:0] page;
        int unsigned       n;
        int unsigned       roll;
        int unsigned       stretch;
        int unsigned       wait_cycles;
        bit                gaps_on;
        const int unsigned RANDOM_ITEMS = 1300;

        rst_n = 1'b0;
        start = 1'b0;
        vaddr = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Fault then TLB hit on the lowest and highest pages, invalid pages at the
        // boundary and at the top of the address space.
        directed_addrs = '{32'h0000_0000, 32'h0000_00FF, 32'h0000_FFFF, 32'h0000_FF00,
                           32'h0001_0000, 32'hFFFF_FFFF, 32'h8000_0000};
        // Sixteen more faults push pages 0 and 255 out of the TLB, so the last two
        // requests hit only in the page table.
        for (n = 1; n <= 16; n++)
            directed_addrs.push_back((n << OFFSET_BITS) | ((n * 17) & 8'hFF));
        directed_addrs.push_back(32'h0000_0012);
        directed_addrs.push_back(32'h0000_FFAA);
        foreach (directed_addrs[k])
            send_request(directed_addrs[k]);

        stretch = 0;
        gaps_on = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (stretch == 0)
            begin
                gaps_on = ($urandom_range(0, 2) != 0);
                stretch = $urandom_range(10, 60);
            end
            stretch--;
            if (n >= RANDOM_ITEMS - 150)
                gaps_on = 1'b0;
            if (gaps_on && $urandom_range(0, 99) < 35)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end

            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                upper = ($urandom_range(0, 9) == 0) ? 16'h0001 : 16'($urandom_range(1, 16'hFFFF));
                va    = {upper, 16'($urandom)};
            end
            else
            begin
                // Revisiting recent pages produces most of the TLB and page table hits.
                if (roll < 60 && recent_pages.size() != 0)
                    page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
                else
                    page = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
                va = (32'(page) << OFFSET_BITS) | 32'($urandom_range(0, (1 << OFFSET_BITS) - 1));
                recent_pages.push_back(page);
                if (recent_pages.size() > 16)
                    void'(recent_pages.pop_front());
            end
            send_request(va);
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (sb.pending_results.size() != 0 && wait_cycles < 200)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (sb.pending_results.size() != 0)
            sb.fail($sformatf("%0d requests never produced a result",
                              sb.pending_results.size()));

        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
